// ===== design/ebalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared types and constants for the 8-bit CPU ALU with flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebalu_pkg;

  localparam int unsigned CmdWidth     = 5;
  localparam int unsigned WordWidth    = 16;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned BitIdxWidth  = 3;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 24;

  typedef enum logic [CmdWidth-1:0] {
    OpAdd   = 5'd0,
    OpAdc   = 5'd1,
    OpSub   = 5'd2,
    OpSbc   = 5'd3,
    OpAnd   = 5'd4,
    OpXor   = 5'd5,
    OpOr    = 5'd6,
    OpCp    = 5'd7,
    OpInc   = 5'd8,
    OpDec   = 5'd9,
    OpRlc   = 5'd10,
    OpRrc   = 5'd11,
    OpRl    = 5'd12,
    OpRr    = 5'd13,
    OpRlca  = 5'd14,
    OpRrca  = 5'd15,
    OpRla   = 5'd16,
    OpRra   = 5'd17,
    OpSla   = 5'd18,
    OpSra   = 5'd19,
    OpSrl   = 5'd20,
    OpSwap  = 5'd21,
    OpBit   = 5'd22,
    OpSet   = 5'd23,
    OpRes   = 5'd24,
    OpDaa   = 5'd25,
    OpCpl   = 5'd26,
    OpScf   = 5'd27,
    OpCcf   = 5'd28,
    OpAdd16 = 5'd29,
    OpAddSp = 5'd30
  } alu_op_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } alu_flags_t;

  typedef struct packed {
    alu_op_e                command;
    logic [WordWidth-1:0]   first_operand;
    logic [WordWidth-1:0]   second_operand;
    logic [BitIdxWidth-1:0] bit_index;
    alu_flags_t             flags;
  } alu_in_t;

  typedef struct packed {
    logic [WordWidth-1:0] result;
    logic                 writes_back;
    alu_flags_t           flags;
  } alu_out_t;

endpackage

// ===== design/ebalu_stage.sv =====
// ----------------------------------------------------------------------------
// ebalu_stage
// One register stage with a valid/ready handshake on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebalu_stage #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic             valid_q;
  logic             valid_d;
  logic [Width-1:0] data_q;

  // The stage takes a new transfer whenever its content leaves in the same cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== design/ebalu_exec.sv =====
// ----------------------------------------------------------------------------
// ebalu_exec
// Combinational datapath: result, write-back mark and new flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebalu_exec (
  input  ebalu_pkg::alu_in_t  op_i,
  output ebalu_pkg::alu_out_t res_o
);
  import ebalu_pkg::*;

  logic [ByteWidth-1:0] a;
  logic [ByteWidth-1:0] v;
  logic                 cin;
  logic                 t;
  logic [ByteWidth:0]   sum9;
  logic [4:0]           sum_lo;
  logic [ByteWidth:0]   diff9;
  logic [4:0]           diff_lo;
  logic [ByteWidth-1:0] inc8;
  logic [ByteWidth-1:0] dec8;
  logic [ByteWidth-1:0] bit_mask;
  logic [ByteWidth-1:0] corr;
  logic [ByteWidth-1:0] daa8;
  logic [WordWidth:0]   sum17;
  logic [12:0]          sum13;
  logic [WordWidth-1:0] sp_sum;
  logic [4:0]           sp_lo;
  logic [ByteWidth:0]   sp_byte;
  logic [WordWidth-1:0] r;
  logic                 wb;
  logic                 zfix;
  alu_flags_t           f;

  assign a   = op_i.first_operand[ByteWidth-1:0];
  assign v   = op_i.second_operand[ByteWidth-1:0];
  assign cin = op_i.flags.c;
  assign t   = ((op_i.command == OpAdc) || (op_i.command == OpSbc)) ? cin : 1'b0;

  assign sum9    = {1'b0, a} + {1'b0, v} + {8'd0, t};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
  // Bit 8 and bit 4 of the differences are the borrows.
  assign diff9   = {1'b0, a} - {1'b0, v} - {8'd0, t};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
  assign inc8    = a + 8'd1;
  assign dec8    = a - 8'd1;
  assign bit_mask = 8'd1 << op_i.bit_index;

  always_comb begin
    corr = cin ? 8'h60 : 8'h00;
    if (op_i.flags.h || (!op_i.flags.n && (a[3:0] > 4'd9))) begin
      corr = corr | 8'h06;
    end
    if (cin || (!op_i.flags.n && (a > 8'h99))) begin
      corr = corr | 8'h60;
    end
  end
  assign daa8 = op_i.flags.n ? (a - corr) : (a + corr);

  assign sum17   = {1'b0, op_i.first_operand} + {1'b0, op_i.second_operand};
  assign sum13   = {1'b0, op_i.first_operand[11:0]} + {1'b0, op_i.second_operand[11:0]};
  assign sp_sum  = op_i.first_operand + {{8{v[7]}}, v};
  assign sp_lo   = {1'b0, op_i.first_operand[3:0]} + {1'b0, v[3:0]};
  assign sp_byte = {1'b0, op_i.first_operand[7:0]} + {1'b0, v};

  always_comb begin
    r    = '0;
    wb   = 1'b1;
    zfix = 1'b1;
    f    = op_i.flags;
    unique case (op_i.command)
      OpAdd, OpAdc: begin
        r   = {8'd0, sum9[7:0]};
        f.n = 1'b0;
        f.h = sum_lo[4];
        f.c = sum9[8];
      end
      OpSub, OpSbc, OpCp: begin
        r   = {8'd0, diff9[7:0]};
        f.n = 1'b1;
        f.h = diff_lo[4];
        f.c = diff9[8];
        if (op_i.command == OpCp) begin
          f.z  = (diff9[7:0] == 8'd0);
          r    = '0;
          wb   = 1'b0;
          zfix = 1'b0;
        end
      end
      OpAnd: begin
        r = {8'd0, a & v};
        f.n = 1'b0; f.h = 1'b1; f.c = 1'b0;
      end
      OpXor: begin
        r = {8'd0, a ^ v};
        f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
      end
      OpOr: begin
        r = {8'd0, a | v};
        f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
      end
      OpInc: begin
        r   = {8'd0, inc8};
        f.n = 1'b0;
        f.h = (inc8[3:0] == 4'h0);
      end
      OpDec: begin
        r   = {8'd0, dec8};
        f.n = 1'b1;
        f.h = (dec8[3:0] == 4'hF);
      end
      OpRlc, OpRlca: begin
        r = {8'd0, a[6:0], a[7]};
        f.c = a[7]; f.n = 1'b0; f.h = 1'b0;
      end
      OpRrc, OpRrca: begin
        r = {8'd0, a[0], a[7:1]};
        f.c = a[0]; f.n = 1'b0; f.h = 1'b0;
      end
      OpRl, OpRla: begin
        r = {8'd0, a[6:0], cin};
        f.c = a[7]; f.n = 1'b0; f.h = 1'b0;
      end
      OpRr, OpRra: begin
        r = {8'd0, cin, a[7:1]};
        f.c = a[0]; f.n = 1'b0; f.h = 1'b0;
      end
      OpSla: begin
        r = {8'd0, a[6:0], 1'b0};
        f.c = a[7]; f.n = 1'b0; f.h = 1'b0;
      end
      OpSra: begin
        r = {8'd0, a[7], a[7:1]};
        f.c = a[0]; f.n = 1'b0; f.h = 1'b0;
      end
      OpSrl: begin
        r = {8'd0, 1'b0, a[7:1]};
        f.c = a[0]; f.n = 1'b0; f.h = 1'b0;
      end
      OpSwap: begin
        r = {8'd0, a[3:0], a[7:4]};
        f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
      end
      OpBit: begin
        f.z  = !a[op_i.bit_index];
        f.n  = 1'b0;
        f.h  = 1'b1;
        wb   = 1'b0;
        zfix = 1'b0;
      end
      OpSet: begin
        r    = {8'd0, a | bit_mask};
        zfix = 1'b0;
      end
      OpRes: begin
        r    = {8'd0, a & ~bit_mask};
        zfix = 1'b0;
      end
      OpDaa: begin
        r   = {8'd0, daa8};
        f.h = 1'b0;
        if (corr[6]) begin
          f.c = 1'b1;
        end
      end
      OpCpl: begin
        r    = {8'd0, ~a};
        f.n  = 1'b1;
        f.h  = 1'b1;
        zfix = 1'b0;
      end
      OpScf: begin
        f.n = 1'b0; f.h = 1'b0; f.c = 1'b1;
        wb = 1'b0; zfix = 1'b0;
      end
      OpCcf: begin
        f.n = 1'b0; f.h = 1'b0; f.c = !cin;
        wb = 1'b0; zfix = 1'b0;
      end
      OpAdd16: begin
        r    = sum17[WordWidth-1:0];
        f.n  = 1'b0;
        f.h  = sum13[12];
        f.c  = sum17[WordWidth];
        zfix = 1'b0;
      end
      OpAddSp: begin
        r    = sp_sum;
        f.z  = 1'b0;
        f.n  = 1'b0;
        f.h  = sp_lo[4];
        f.c  = sp_byte[8];
        zfix = 1'b0;
      end
      default: begin
        // The unused code leaves every flag untouched and writes nothing.
        wb   = 1'b0;
        zfix = 1'b0;
      end
    endcase

    if (zfix) begin
      f.z = (r == '0);
    end
    // The accumulator rotates always clear the zero flag.
    if ((op_i.command == OpRlca) || (op_i.command == OpRrca) ||
        (op_i.command == OpRla) || (op_i.command == OpRra)) begin
      f.z = 1'b0;
    end
  end

  assign res_o.result      = r;
  assign res_o.writes_back = wb;
  assign res_o.flags       = f;

endmodule

// ===== design/eight_bit_cpu_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_core
// 8-bit CPU ALU with zero, subtract, half-carry and carry flags.
// ----------------------------------------------------------------------------
// The block takes one operation per cycle while m_axis_tready_i stays high. Each
// result passes through the input register and then the result register, with
// the whole operation computed by the logic between them. Either register takes
// a new transfer in the same cycle that its content moves on, so the throughput
// is one operation per clock while the output side keeps m_axis_tready_i high.
// Each input transfer gives exactly one output transfer, in order.
`timescale 1ns / 1ps

module eight_bit_cpu_alu_with_flags_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // command[4:0], first_operand[20:5], second_operand[36:21], bit_index[39:37],
  // zero_in[40], subtract_in[41], half_carry_in[42], carry_in[43], zeros above
  input  logic [ebalu_pkg::InDataWidth-1:0]    s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // result[15:0], writes_back[16], zero_out[17], subtract_out[18],
  // half_carry_out[19], carry_out[20], zeros above
  output logic [ebalu_pkg::OutDataWidth-1:0]   m_axis_tdata_o
);
  import ebalu_pkg::*;

  alu_in_t  in_item;
  alu_in_t  op_q;
  alu_out_t res;
  alu_out_t res_q;
  logic     op_valid;
  logic     op_ready;

  assign in_item.command        = alu_op_e'(s_axis_tdata_i[4:0]);
  assign in_item.first_operand  = s_axis_tdata_i[20:5];
  assign in_item.second_operand = s_axis_tdata_i[36:21];
  assign in_item.bit_index      = s_axis_tdata_i[39:37];
  assign in_item.flags.z        = s_axis_tdata_i[40];
  assign in_item.flags.n        = s_axis_tdata_i[41];
  assign in_item.flags.h        = s_axis_tdata_i[42];
  assign in_item.flags.c        = s_axis_tdata_i[43];

  ebalu_stage #(
    .Width($bits(alu_in_t))
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (in_item),
    .out_valid_o(op_valid),
    .out_ready_i(op_ready),
    .out_data_o (op_q)
  );

  ebalu_exec u_exec (
    .op_i (op_q),
    .res_o(res)
  );

  ebalu_stage #(
    .Width($bits(alu_out_t))
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (op_valid),
    .in_ready_o (op_ready),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (res_q)
  );

  assign m_axis_tdata_o = {3'd0, res_q.flags.c, res_q.flags.h, res_q.flags.n,
                           res_q.flags.z, res_q.writes_back, res_q.result};

endmodule
